/* hdl/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH  = 1024;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 11;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK       = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // what a row of cells does when clocked
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_SHIFT_IN,   // new value enters at the head, all move one toward the tail
    CH_SHIFT_OUT,  // all move one toward the head, head drops out
    CH_WRITE_TAIL  // the cell whose index equals count takes the value
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    count_t    count;
    data_t     value;
  } chain_ctl_t;

  localparam data_t EMPTY_MARK = '1;

endpackage

/* hdl/double_ended_queue.sv */
// Double-ended queue of DEPTH signed 32-bit entries. One item is accepted per
// cycle and its result is presented the cycle after; a held result does not
// stall input as long as out_ready takes it in the same cycle. The contents
// live in two mirrored shift chains of DEPTH cells: one keeps the front at
// its head, the other keeps the back at its head, so both ends are read and
// updated in a single cycle with no addressed memory. A push into a full
// queue is dropped (status 2); a pop on an empty queue returns -1 (status 1).
// Mode codes 5 to 7 act as peek.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       mode,
  input  data_t            push_value,
  output logic             out_valid,
  input  logic             out_ready,
  output data_t            popped_value,
  output logic [OCC_W-1:0] occupancy,
  output logic             is_empty,
  output data_t            front_value,
  output data_t            back_value,
  output logic [1:0]       status
);

  count_t     count;
  count_t     count_next;
  chain_ctl_t fwd_ctl;
  chain_ctl_t rev_ctl;
  data_t      fwd_head;
  data_t      rev_head;
  data_t      popped_next;
  status_t    status_next;
  logic       accept;
  logic       full;
  logic       empty;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    fwd_ctl.op    = CH_HOLD;
    fwd_ctl.count = count;
    fwd_ctl.value = push_value;
    rev_ctl.op    = CH_HOLD;
    rev_ctl.count = count;
    rev_ctl.value = push_value;
    count_next    = count;
    popped_next   = EMPTY_MARK;
    status_next   = ST_DONE;
    if (accept) begin
      unique case (mode)
        MODE_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            fwd_ctl.op = CH_SHIFT_IN;
            rev_ctl.op = CH_WRITE_TAIL;
            count_next = count + count_t'(1);
          end
        end
        MODE_PUSH_BACK: begin
          if (full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            fwd_ctl.op = CH_WRITE_TAIL;
            rev_ctl.op = CH_SHIFT_IN;
            count_next = count + count_t'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            popped_next = fwd_head;
            fwd_ctl.op  = CH_SHIFT_OUT;
            count_next  = count - count_t'(1);
          end
        end
        MODE_POP_BACK: begin
          if (empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            popped_next = rev_head;
            rev_ctl.op  = CH_SHIFT_OUT;
            count_next  = count - count_t'(1);
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  deq_chain u_fwd (
    .clk  (clk),
    .ctl  (fwd_ctl),
    .head (fwd_head)
  );

  deq_chain u_rev (
    .clk  (clk),
    .ctl  (rev_ctl),
    .head (rev_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= popped_next;
      status       <= status_next;
    end
  end

  // state only moves on a transfer, so the live state matches the held result
  assign occupancy   = OCC_W'(count);
  assign is_empty    = empty;
  assign front_value = empty ? EMPTY_MARK : fwd_head;
  assign back_value  = empty ? EMPTY_MARK : rev_head;

endmodule

/* hdl/deq_cell.sv */
module deq_cell
  import deq_pkg::*;
(
  input  logic      clk,
  input  chain_op_t op,
  input  logic      hit,
  input  data_t     value,
  input  data_t     from_prev,
  input  data_t     from_next,
  output data_t     data
);

  data_t data_next;

  always_comb begin
    data_next = data;
    case (op)
      CH_SHIFT_IN:   data_next = from_prev;
      CH_SHIFT_OUT:  data_next = from_next;
      CH_WRITE_TAIL: if (hit) data_next = value;
      default:       data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* hdl/deq_chain.sv */
module deq_chain
  import deq_pkg::*;
(
  input  logic       clk,
  input  chain_ctl_t ctl,
  output data_t      head
);

  data_t cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t prev_d;
    data_t next_d;
    logic  hit;

    if (i == 0) begin : g_first
      assign prev_d = ctl.value;
    end else begin : g_mid
      assign prev_d = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cells[i+1];
    end

    assign hit = (ctl.count == CNT_W'(i));

    deq_cell u_cell (
      .clk       (clk),
      .op        (ctl.op),
      .hit       (hit),
      .value     (ctl.value),
      .from_prev (prev_d),
      .from_next (next_d),
      .data      (cells[i])
    );
  end

  assign head = cells[0];

endmodule

/* tb/sv/double_ended_queue_test.sv */
`timescale 1ns / 1ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_TAIL  = 150;
  localparam int MIXED_ITEMS = 250;
  localparam int FULL_ITEMS  = 12;
  localparam int DRAIN_ITEMS = 330;

  // codes outside the defined set act as peek
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  typedef struct {
    data_t            popped;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    data_t            front;
    data_t            back;
    logic [1:0]       status;
  } deq_result_t;

  class deque_scoreboard;
    data_t       ring [DEPTH];
    int unsigned head;
    int unsigned count;
    deq_result_t pending_results [$];
    int          errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned back_slot();
      return (head + count - 1) % DEPTH;
    endfunction

    // apply one transfer to the shadow deque and queue its expected result
    function void note_request(logic [2:0] m, data_t v);
      deq_result_t r;
      r.popped = EMPTY_MARK;
      r.status = ST_DONE;
      case (m)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (count >= DEPTH) begin
            r.status = ST_PUSH_FULL;
          end else if (m == MODE_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = v;
            count++;
          end else begin
            ring[(head + count) % DEPTH] = v;
            count++;
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (count == 0) begin
            r.status = ST_POP_EMPTY;
          end else if (m == MODE_POP_FRONT) begin
            r.popped = ring[head];
            head = (head + 1) % DEPTH;
            count--;
          end else begin
            r.popped = ring[back_slot()];
            count--;
          end
        end
        default: ;
      endcase
      r.occupancy = count[OCC_W-1:0];
      r.is_empty  = (count == 0);
      r.front     = (count == 0) ? EMPTY_MARK : ring[head];
      r.back      = (count == 0) ? EMPTY_MARK : ring[back_slot()];
      pending_results = {pending_results, r};
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(deq_result_t got);
      deq_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      compare("popped_value", want.popped, got.popped);
      compare("occupancy", want.occupancy, got.occupancy);
      compare("is_empty", want.is_empty, got.is_empty);
      compare("front_value", want.front, got.front);
      compare("back_value", want.back, got.back);
      compare("status", want.status, got.status);
    endfunction
  endclass

  logic             clk;
  logic             rst        = 1'b1;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic [2:0]       mode       = MODE_PEEK;
  data_t            push_value = '0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  data_t            popped_value;
  logic [OCC_W-1:0] occupancy;
  logic             is_empty;
  data_t            front_value;
  data_t            back_value;
  logic [1:0]       status;

  deque_scoreboard sb = new();
  bit              no_idle = 1'b0;
  int              cycle_count = 0;

  double_ended_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .occupancy    (occupancy),
    .is_empty     (is_empty),
    .front_value  (front_value),
    .back_value   (back_value),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    deq_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.popped    = popped_value;
      got.occupancy = occupancy;
      got.is_empty  = is_empty;
      got.front     = front_value;
      got.back      = back_value;
      got.status    = status;
      sb.check_result(got);
    end
  end

  // result side backpressure
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [2:0] m, data_t v);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    push_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, v);
  endtask

  function automatic logic [2:0] any_push();
    return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
  endfunction

  function automatic logic [2:0] any_pop();
    return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue corners, reserved codes, extreme values at both ends
    send_item(MODE_PEEK, pick_value());
    send_item(MODE_POP_FRONT, 32'sh7fff_ffff);
    send_item(MODE_POP_BACK, 32'sh8000_0000);
    send_item(MODE_RSVD5, pick_value());
    send_item(MODE_RSVD6, pick_value());
    send_item(MODE_RSVD7, pick_value());
    send_item(MODE_PUSH_BACK, 32'sh7fff_ffff);
    send_item(MODE_PUSH_FRONT, 32'sh8000_0000);
    send_item(MODE_PEEK, '0);
    send_item(MODE_PUSH_BACK, '0);
    send_item(MODE_PUSH_FRONT, -32'sd1);
    send_item(MODE_POP_BACK, pick_value());
    send_item(MODE_POP_FRONT, pick_value());
    send_item(MODE_RSVD5, pick_value());
    send_item(MODE_POP_FRONT, pick_value());
    send_item(MODE_POP_BACK, pick_value());
    send_item(MODE_POP_BACK, pick_value());
    send_item(MODE_PUSH_FRONT, 32'sh5a5a_a5a5);
    send_item(MODE_POP_BACK, pick_value());
    send_item(MODE_PUSH_BACK, 32'sh1234_5678);
    send_item(MODE_POP_FRONT, pick_value());

    // shallow occupancy, any code
    repeat (MIXED_ITEMS) send_item(3'($urandom_range(0, 7)), pick_value());

    // fill to capacity from both ends so the ring wraps
    while (sb.count < DEPTH) begin
      if ($urandom_range(0, 99) < 88)
        send_item(any_push(), pick_value());
      else
        send_item(3'($urandom_range(MODE_POP_FRONT, MODE_RSVD7)), pick_value());
    end

    // around the full boundary: dropped pushes, refills after pops
    repeat (FULL_ITEMS) begin
      if ($urandom_range(0, 3) != 0)
        send_item(any_push(), pick_value());
      else
        send_item(3'($urandom_range(0, 7)), pick_value());
    end

    // drain from both ends; no idling near the end
    for (int i = 0; i < DRAIN_ITEMS; i++) begin
      if (i == DRAIN_ITEMS - QUIET_TAIL)
        no_idle = 1'b1;
      if ($urandom_range(0, 99) < 85)
        send_item(any_pop(), pick_value());
      else
        send_item(3'($urandom_range(0, 7)), pick_value());
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
